### design/sort_and_unique_unit_assert.svh
`ifndef SORT_AND_UNIQUE_UNIT_ASSERT_SVH
`define SORT_AND_UNIQUE_UNIT_ASSERT_SVH

// same-cycle check, reset masked
`define SU_ASSERT_NOW(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sort_and_unique_unit: check failed");

// next-cycle check, reset masked
`define SU_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sort_and_unique_unit: check failed");

`endif

### design/su_pkg.sv
package su_pkg;
	localparam int CAP   = 64;
	localparam int VAL_W = 64;
	localparam int CNT_W = $clog2(CAP + 1);
	localparam int OUT_DATA_W = ((VAL_W + CNT_W + 7) / 8) * 8;

	typedef struct packed {
		logic signed [VAL_W-1:0] value;
		logic                    last;
		logic                    store;
		logic                    ovf;
	} su_item_t;

	typedef enum logic {
		SU_FILL,
		SU_DRAIN
	} su_state_t;
endpackage

### design/su_front.sv
module su_front
	import su_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [VAL_W-1:0] in_value,
	input  logic                    in_last,
	output logic                    push,
	output su_item_t                item,
	input  logic                    q_full
);
	logic [CNT_W-1:0] fill_q;
	logic             ovf_q;
	logic             has_room;
	logic             acc;

	assign in_ready = !q_full;
	assign acc      = in_valid && in_ready;
	assign has_room = (fill_q < CNT_W'(CAP));

	assign push       = acc;
	assign item.value = in_value;
	assign item.last  = in_last;
	assign item.store = has_room;
	assign item.ovf   = ovf_q || !has_room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_q <= '0;
			ovf_q  <= 1'b0;
		end else if (acc) begin
			if (in_last) begin
				fill_q <= '0;
				ovf_q  <= 1'b0;
			end else if (has_room) begin
				fill_q <= fill_q + CNT_W'(1);
			end else begin
				ovf_q <= 1'b1;
			end
		end
	end
endmodule

### design/su_fifo.sv
module su_fifo
	import su_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     push,
	input  su_item_t wr_item,
	output logic     full,
	input  logic     pop,
	output logic     rd_valid,
	output su_item_t rd_item
);
	su_item_t   mem_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] cnt_q;
	logic       do_pop;

	assign full     = (cnt_q == 2'd2);
	assign rd_valid = (cnt_q != 2'd0);
	assign rd_item  = mem_q[rd_ptr_q];
	assign do_pop   = pop && rd_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			cnt_q    <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (do_pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			cnt_q <= cnt_q + 2'(push) - 2'(do_pop);
		end
	end
endmodule

### design/su_back.sv
module su_back
	import su_pkg::*;
(
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    q_valid,
	input  su_item_t                q_item,
	output logic                    pop,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic signed [VAL_W-1:0] out_value,
	output logic                    out_end,
	output logic [CNT_W-1:0]        out_count,
	output logic                    out_ovf
);
	logic signed [VAL_W-1:0] cell_q [CAP];
	logic [CAP-1:0]          vld_q;
	logic [CAP-1:0]          ins;
	logic [CAP-1:0]          hit;
	logic [CNT_W-1:0]        uniq_q;
	logic                    ovf_q;
	su_state_t               st_q;
	su_state_t               st_nx;
	logic                    ld;
	logic                    do_ins;
	logic                    dup;

	logic signed [VAL_W-1:0] o_val_q;
	logic                    o_vld_q;
	logic                    o_end_q;
	logic [CNT_W-1:0]        o_cnt_q;
	logic                    o_ovf_q;

	// compare row: insertion point and duplicate hits
	for (genvar i = 0; i < CAP; i++) begin : g_cmp
		assign ins[i] = !vld_q[i] || (q_item.value < cell_q[i]);
		assign hit[i] = vld_q[i] && (q_item.value == cell_q[i]);
	end
	assign dup = |hit;

	always_comb begin
		st_nx = st_q;
		case (st_q)
			SU_FILL: begin
				if (pop && q_item.last) begin
					st_nx = SU_DRAIN;
				end
			end
			SU_DRAIN: begin
				if (ld && !vld_q[1]) begin
					st_nx = SU_FILL;
				end
			end
			default: st_nx = SU_FILL;
		endcase
	end

	always_comb begin
		pop = 1'b0;
		ld  = 1'b0;
		case (st_q)
			SU_FILL:  pop = q_valid;
			SU_DRAIN: ld  = !o_vld_q || out_ready;
			default: begin
				pop = 1'b0;
				ld  = 1'b0;
			end
		endcase
	end

	assign do_ins = pop && q_item.store && !dup;

	// sorted chain: insert shifts up, drain shifts down
	for (genvar i = 0; i < CAP; i++) begin : g_cell
		always_ff @(posedge clk) begin
			if (do_ins && ins[i]) begin
				if (i == 0) begin
					cell_q[i] <= q_item.value;
				end else if (!ins[(i == 0) ? 0 : i-1]) begin
					cell_q[i] <= q_item.value;
				end else begin
					cell_q[i] <= cell_q[(i == 0) ? 0 : i-1];
				end
			end else if (ld && (i < CAP - 1)) begin
				cell_q[i] <= cell_q[(i < CAP - 1) ? i+1 : i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q   <= '0;
			uniq_q  <= '0;
			ovf_q   <= 1'b0;
			st_q    <= SU_FILL;
			o_vld_q <= 1'b0;
		end else begin
			st_q <= st_nx;
			if (do_ins) begin
				vld_q  <= {vld_q[CAP-2:0], 1'b1};
				uniq_q <= uniq_q + CNT_W'(1);
			end else if (ld) begin
				vld_q <= {1'b0, vld_q[CAP-1:1]};
				if (!vld_q[1]) begin
					uniq_q <= '0;
				end
			end
			if (pop && q_item.last) begin
				ovf_q <= q_item.ovf;
			end
			if (ld) begin
				o_vld_q <= 1'b1;
			end else if (out_ready) begin
				o_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ld) begin
			o_val_q <= cell_q[0];
			o_end_q <= !vld_q[1];
			o_cnt_q <= uniq_q;
			o_ovf_q <= ovf_q;
		end
	end

	assign out_valid = o_vld_q;
	assign out_value = o_val_q;
	assign out_end   = o_end_q;
	assign out_count = o_cnt_q;
	assign out_ovf   = o_ovf_q;

`include "sort_and_unique_unit_assert.svh"

	`SU_ASSERT_NOW(a_chain_packed, 1'b1, ((vld_q + CAP'(1)) & vld_q) == '0)
	`SU_ASSERT_NOW(a_drain_nonempty, st_q == SU_DRAIN, vld_q[0])
	`SU_ASSERT_NOW(a_count_match, st_q == SU_FILL, uniq_q == CNT_W'($countones(vld_q)))
	`SU_ASSERT_NEXT(a_end_to_fill, ld && !vld_q[1], st_q == SU_FILL && vld_q == '0)
endmodule

### design/sort_and_unique_unit.sv
// sort_and_unique_unit: collects a set of signed 64-bit words and returns
// its distinct values in ascending order
// input s_*: one value per word, s_tlast on the final word of the set
// output m_*: one word per distinct value, m_tlast on the largest,
// every word carries the distinct count and the overflow flag
// up to 64 values are kept per set, later ones are dropped and flagged
// a two-entry queue sits between the input side and the insertion chain
// after the last word the chain drains one distinct value per cycle while m_tready is high;
// the first result passes the queue, the switch to drain and the output register
// m_tready low holds the output register and stops the drain; input
// words are still taken until the queue fills
// reset empties queue and chain and clears count and overflow flag
module sort_and_unique_unit
	import su_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_tvalid,
	output logic                  s_tready,
	input  logic [VAL_W-1:0]      s_tdata,  // value
	input  logic                  s_tlast,  // last
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [OUT_DATA_W-1:0] m_tdata,  // unique_value, unique_count, zero pad
	output logic                  m_tlast,  // run_end
	output logic                  m_tuser   // overflowed
);
	logic                    push;
	su_item_t                f_item;
	logic                    q_full;
	logic                    pop;
	logic                    q_valid;
	su_item_t                q_item;
	logic signed [VAL_W-1:0] o_value;
	logic [CNT_W-1:0]        o_count;

	su_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_value (s_tdata),
		.in_last  (s_tlast),
		.push     (push),
		.item     (f_item),
		.q_full   (q_full)
	);

	su_fifo u_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_item  (f_item),
		.full     (q_full),
		.pop      (pop),
		.rd_valid (q_valid),
		.rd_item  (q_item)
	);

	su_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_item    (q_item),
		.pop       (pop),
		.out_valid (m_tvalid),
		.out_ready (m_tready),
		.out_value (o_value),
		.out_end   (m_tlast),
		.out_count (o_count),
		.out_ovf   (m_tuser)
	);

	assign m_tdata = {{(OUT_DATA_W - VAL_W - CNT_W){1'b0}}, o_count, o_value};
endmodule
